>>> rtl/hcq_pkg.sv
package hcq_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register map
  typedef enum logic [2:0] {
    CFG_MAP_WIDTH    = 3'd0,
    CFG_MAP_DEPTH    = 3'd1,
    CFG_CHUNK_SIZE   = 3'd2,
    CFG_HEIGHT_MIN   = 3'd3,
    CFG_HEIGHT_SCALE = 3'd4,
    CFG_WORLD_SCALE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_BOX       = 2'd1,
    KIND_FINAL_BOX = 2'd2
  } kind_t;

  // 65535 in Q.24: products at or above this saturate the code
  localparam logic [63:0] CODE_LIMIT = 64'h0000_00FF_FF00_0000;
  localparam logic [39:0] ROUND_HALF = 40'h00_0080_0000;
  localparam logic [15:0] CODE_MAX   = 16'hFFFF;

  typedef struct packed {
    kind_t              result_kind;
    logic [15:0]        quantized_height;
    logic [23:0]        chunk_index;
    logic [15:0]        local_index;
    logic [23:0]        next_source_address;
    logic [36:0]        box_min_x;
    logic signed [31:0] box_min_y;
    logic [36:0]        box_min_z;
    logic [36:0]        box_max_x;
    logic signed [31:0] box_max_y;
    logic [36:0]        box_max_z;
    logic               last_of_run;
  } res_t;

endpackage

>>> rtl/hcq_fifo.sv
module hcq_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output item_t pop_data,
  output logic  empty
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/hcq_front.sv
module hcq_front #(
  parameter int  MAX_DIM   = 4096,
  parameter int  MAX_CHUNK = 256,
  parameter type mid_t     = logic
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           restart,
  input  logic [$clog2(MAX_DIM+1)-1:0]   eff_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]   eff_d,
  input  logic [$clog2(MAX_CHUNK)-1:0]   step,
  input  logic signed [31:0]             height_min,
  input  logic                           in_push,
  input  logic signed [31:0]             in_height,
  output logic                           in_full,
  output logic                           mid_push,
  output mid_t                           mid_item,
  input  logic                           mid_full
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int BW    = $clog2(MAX_DIM);
  localparam int LW    = $clog2(MAX_CHUNK);
  localparam int SW    = ((DIM_W > LW) ? DIM_W : LW) + 1;

  logic [LW-1:0]      col_r, col_nxt;
  logic [LW-1:0]      row_r, row_nxt;
  logic [BW-1:0]      bx_r, bx_nxt;
  logic [BW-1:0]      bz_r, bz_nxt;
  logic [23:0]        chunk_r, chunk_nxt;
  logic [15:0]        lidx_r, lidx_nxt;
  logic signed [31:0] min_r, min_nxt;
  logic signed [31:0] max_r, max_nxt;
  logic               accept;
  logic               col_end, row_end, chunk_end;
  logic               last_col, last_row, first;
  logic [SW-1:0]      bx_step, bz_step, w_last, d_last, gx_raw, gz_raw;
  logic [32:0]        diff;

  assign in_full  = mid_full;
  assign accept   = in_push && !mid_full;
  assign mid_push = accept;

  always_comb begin
    col_end   = (col_r >= step);
    row_end   = (row_r >= step);
    chunk_end = col_end && row_end;
    bx_step   = SW'(bx_r) + SW'(step);
    bz_step   = SW'(bz_r) + SW'(step);
    w_last    = SW'(eff_w) - SW'(1);
    d_last    = SW'(eff_d) - SW'(1);
    last_col  = (bx_step >= w_last);
    last_row  = (bz_step >= d_last);

    // advance the walk: column, then row, then chunk
    col_nxt   = col_end ? '0 : col_r + LW'(1);
    row_nxt   = row_r;
    bx_nxt    = bx_r;
    bz_nxt    = bz_r;
    chunk_nxt = chunk_r;
    if (col_end) begin
      if (!row_end) begin
        row_nxt = row_r + LW'(1);
      end else begin
        row_nxt = '0;
        if (!last_col) begin
          bx_nxt    = BW'(bx_step);
          chunk_nxt = chunk_r + 24'd1;
        end else if (!last_row) begin
          bx_nxt    = '0;
          bz_nxt    = BW'(bz_step);
          chunk_nxt = chunk_r + 24'd1;
        end else begin
          bx_nxt    = '0;
          bz_nxt    = '0;
          chunk_nxt = '0;
        end
      end
    end
    lidx_nxt = chunk_end ? '0 : lidx_r + 16'd1;

    // first sample of a chunk replaces the running bounds
    first   = (col_r == '0) && (row_r == '0);
    min_nxt = (first || (in_height < min_r)) ? in_height : min_r;
    max_nxt = (first || (in_height > max_r)) ? in_height : max_r;

    gx_raw = SW'(bx_nxt) + SW'(col_nxt);
    gz_raw = SW'(bz_nxt) + SW'(row_nxt);
    diff   = {in_height[31], in_height} - {height_min[31], height_min};

    mid_item.d_pos       = !diff[32] && (diff[31:0] != '0);
    mid_item.d_mag       = diff[31:0];
    mid_item.chunk       = chunk_r;
    mid_item.local_idx   = lidx_r;
    mid_item.gx          = (gx_raw > w_last) ? BW'(w_last) : BW'(gx_raw);
    mid_item.gz          = (gz_raw > d_last) ? BW'(d_last) : BW'(gz_raw);
    mid_item.bx          = bx_r;
    mid_item.bz          = bz_r;
    mid_item.chunk_end   = chunk_end;
    mid_item.final_chunk = chunk_end && last_col && last_row;
    mid_item.run_min     = min_nxt;
    mid_item.run_max     = max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      row_r   <= '0;
      bx_r    <= '0;
      bz_r    <= '0;
      chunk_r <= '0;
      lidx_r  <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bx_r    <= bx_nxt;
      bz_r    <= bz_nxt;
      chunk_r <= chunk_nxt;
      lidx_r  <= lidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
    end else if (accept) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

>>> rtl/hcq_back.sv
module hcq_back #(
  parameter int  MAX_DIM   = 4096,
  parameter int  MAX_CHUNK = 256,
  parameter type mid_t     = logic
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(MAX_DIM+1)-1:0] eff_w,
  input  logic [$clog2(MAX_CHUNK)-1:0] step,
  input  logic [31:0]                  height_scale,
  input  logic [23:0]                  world_scale,
  input  mid_t                         mid_item,
  input  logic                         mid_empty,
  output logic                         mid_pop,
  output hcq_pkg::res_t                res_item,
  output logic                         res_push,
  input  logic                         res_full
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int BW    = $clog2(MAX_DIM);
  localparam int LW    = $clog2(MAX_CHUNK);
  localparam int SW    = ((DIM_W > LW) ? DIM_W : LW) + 1;
  localparam int AW    = BW + DIM_W;
  localparam int XW    = BW + 24;
  localparam int YW    = SW + 24;

  logic               s1_valid_r;
  logic               phase_r;
  logic [63:0]        prod_r, prod;
  logic [23:0]        addr_r;
  logic [36:0]        min_x_r, min_z_r, max_x_r, max_z_r;
  logic [23:0]        chunk_r;
  logic [15:0]        lidx_r;
  logic               chunk_end_r, final_r;
  logic signed [31:0] run_min_r, run_max_r;
  logic [31:0]        d_eff;
  logic [AW-1:0]      addr_full;
  logic [XW-1:0]      min_x_full, min_z_full;
  logic [YW-1:0]      max_x_full, max_z_full;
  logic               s1_done, s1_take;
  logic               sat;
  logic [39:0]        rounded;
  logic [15:0]        code;

  // multiplier stage inputs, straight off the queue head
  always_comb begin
    d_eff      = mid_item.d_pos ? mid_item.d_mag : '0;
    prod       = 64'(d_eff) * 64'(height_scale);
    addr_full  = AW'(mid_item.gz) * AW'(eff_w) + AW'(mid_item.gx);
    min_x_full = XW'(mid_item.bx) * XW'(world_scale);
    min_z_full = XW'(mid_item.bz) * XW'(world_scale);
    max_x_full = (YW'(mid_item.bx) + YW'(step)) * YW'(world_scale);
    max_z_full = (YW'(mid_item.bz) + YW'(step)) * YW'(world_scale);
  end

  // a chunk-end item holds the stage for a second beat carrying its box
  assign res_push = s1_valid_r && !res_full;
  assign s1_done  = res_push && (phase_r || !chunk_end_r);
  assign s1_take  = !s1_valid_r || s1_done;
  assign mid_pop  = s1_take && !mid_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= 1'b0;
    end else if (mid_pop) begin
      s1_valid_r <= 1'b1;
      phase_r    <= 1'b0;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end else if (res_push) begin
      phase_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      prod_r      <= prod;
      addr_r      <= 24'(addr_full);
      min_x_r     <= 37'(min_x_full);
      min_z_r     <= 37'(min_z_full);
      max_x_r     <= 37'(max_x_full);
      max_z_r     <= 37'(max_z_full);
      chunk_r     <= mid_item.chunk;
      lidx_r      <= mid_item.local_idx;
      chunk_end_r <= mid_item.chunk_end;
      final_r     <= mid_item.final_chunk;
      run_min_r   <= mid_item.run_min;
      run_max_r   <= mid_item.run_max;
    end
  end

  always_comb begin
    sat     = (prod_r >= hcq_pkg::CODE_LIMIT);
    rounded = prod_r[39:0] + hcq_pkg::ROUND_HALF;
    code    = sat ? hcq_pkg::CODE_MAX : rounded[39:24];

    res_item                     = '0;
    res_item.chunk_index         = chunk_r;
    res_item.next_source_address = addr_r;
    if (!phase_r) begin
      res_item.result_kind      = hcq_pkg::KIND_SAMPLE;
      res_item.quantized_height = code;
      res_item.local_index      = lidx_r;
      res_item.last_of_run      = !chunk_end_r;
    end else begin
      res_item.result_kind = final_r ? hcq_pkg::KIND_FINAL_BOX : hcq_pkg::KIND_BOX;
      res_item.box_min_x   = min_x_r;
      res_item.box_min_y   = run_min_r;
      res_item.box_min_z   = min_z_r;
      res_item.box_max_x   = max_x_r;
      res_item.box_max_y   = run_max_r;
      res_item.box_max_z   = max_z_r;
      res_item.last_of_run = 1'b1;
    end
  end

endmodule

>>> rtl/heightfield_chunk_quantizer_top.sv
// Height-map chunk quantizer. Push one height sample (Q23.8) per clock while in_full is low;
// every sample yields one sample result, and the last sample of each chunk also yields a
// bounding-box result right after it, so a chunk of N samples costs N + 1 result beats.
// The back end writes one result per clock into the result queue while that queue is not
// full, and takes no new sample while it writes a box beat. A sample reaches the out_ ports
// through the mid queue, the back-end register stage and the result queue. out_next_source_address in
// each result is the map address to fetch next (row and column clamped at the right and
// bottom borders); the walk starts at address 0 after reset. Chunks overlap by one edge row
// and column and are walked in row order; after the final chunk the walk wraps to chunk 0.
// Configuration is taken on cfg_valid (cfg_ready is always high) and must only be written
// while the block is drained; writing map_width, map_depth or chunk_size restarts the walk.
// Writes to an unused index are dropped.
module heightfield_chunk_quantizer_top #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_CHUNK = 256,
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample input
  input  logic                             in_push,
  output logic                             in_full,
  input  logic signed [31:0]               in_height,
  // results
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [1:0]                       out_result_kind,
  output logic [15:0]                      out_quantized_height,
  output logic [23:0]                      out_chunk_index,
  output logic [15:0]                      out_local_index,
  output logic [23:0]                      out_next_source_address,
  output logic [36:0]                      out_box_min_x,
  output logic signed [31:0]               out_box_min_y,
  output logic [36:0]                      out_box_min_z,
  output logic [36:0]                      out_box_max_x,
  output logic signed [31:0]               out_box_max_y,
  output logic [36:0]                      out_box_max_z,
  output logic                             out_last_of_run,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hcq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int BW     = $clog2(MAX_DIM);
  localparam int LW     = $clog2(MAX_CHUNK);
  localparam int CW     = $clog2(MAX_CHUNK + 1);
  localparam int EXT_W  = DIM_W + 13;
  localparam int CEXT_W = CW + 9;

  localparam logic [12:0] MAP_WIDTH_RST   = 13'd256;
  localparam logic [12:0] MAP_DEPTH_RST   = 13'd256;
  localparam logic [8:0]  CHUNK_SIZE_RST  = 9'd65;
  localparam logic [23:0] WORLD_SCALE_RST = 24'd65536;

  // one queue entry per accepted sample, front to back
  typedef struct packed {
    logic               d_pos;
    logic [31:0]        d_mag;
    logic [23:0]        chunk;
    logic [15:0]        local_idx;
    logic [BW-1:0]      gx;
    logic [BW-1:0]      gz;
    logic [BW-1:0]      bx;
    logic [BW-1:0]      bz;
    logic               chunk_end;
    logic               final_chunk;
    logic signed [31:0] run_min;
    logic signed [31:0] run_max;
  } mid_t;

  logic [12:0]        map_width_r;
  logic [12:0]        map_depth_r;
  logic [8:0]         chunk_size_r;
  logic signed [31:0] height_min_r;
  logic [31:0]        height_scale_r;
  logic [23:0]        world_scale_r;

  logic               cfg_we;
  logic               restart;
  logic [EXT_W-1:0]   w_ext, d_ext;
  logic [CEXT_W-1:0]  c_ext;
  logic [DIM_W-1:0]   eff_w, eff_d;
  logic [CW-1:0]      eff_c;
  logic [LW-1:0]      step;

  mid_t               front_item, back_item;
  logic               mid_push, mid_full, mid_pop, mid_empty;
  hcq_pkg::res_t      res_item, out_item;
  logic               res_push, res_full;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r    <= MAP_WIDTH_RST;
      map_depth_r    <= MAP_DEPTH_RST;
      chunk_size_r   <= CHUNK_SIZE_RST;
      height_min_r   <= '0;
      height_scale_r <= '0;
      world_scale_r  <= WORLD_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcq_pkg::CFG_MAP_WIDTH:    map_width_r    <= cfg_data[12:0];
        hcq_pkg::CFG_MAP_DEPTH:    map_depth_r    <= cfg_data[12:0];
        hcq_pkg::CFG_CHUNK_SIZE:   chunk_size_r   <= cfg_data[8:0];
        hcq_pkg::CFG_HEIGHT_MIN:   height_min_r   <= cfg_data[31:0];
        hcq_pkg::CFG_HEIGHT_SCALE: height_scale_r <= cfg_data[31:0];
        hcq_pkg::CFG_WORLD_SCALE:  world_scale_r  <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // geometry writes restart the walk
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index) inside
        hcq_pkg::CFG_MAP_WIDTH, hcq_pkg::CFG_MAP_DEPTH, hcq_pkg::CFG_CHUNK_SIZE: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  // clamp geometry to its legal range
  always_comb begin
    w_ext = EXT_W'(map_width_r);
    d_ext = EXT_W'(map_depth_r);
    c_ext = CEXT_W'(chunk_size_r);

    if (w_ext < EXT_W'(2)) begin
      eff_w = DIM_W'(2);
    end else if (w_ext > EXT_W'(MAX_DIM)) begin
      eff_w = DIM_W'(MAX_DIM);
    end else begin
      eff_w = DIM_W'(w_ext);
    end

    if (d_ext < EXT_W'(2)) begin
      eff_d = DIM_W'(2);
    end else if (d_ext > EXT_W'(MAX_DIM)) begin
      eff_d = DIM_W'(MAX_DIM);
    end else begin
      eff_d = DIM_W'(d_ext);
    end

    if (c_ext < CEXT_W'(2)) begin
      eff_c = CW'(2);
    end else if (c_ext > CEXT_W'(MAX_CHUNK)) begin
      eff_c = CW'(MAX_CHUNK);
    end else begin
      eff_c = CW'(c_ext);
    end

    step = LW'(eff_c - CW'(1));
  end

  // front: walk, next-fetch coordinates, running bounds, height offset
  hcq_front #(
    .MAX_DIM   (MAX_DIM),
    .MAX_CHUNK (MAX_CHUNK),
    .mid_t     (mid_t)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .eff_w      (eff_w),
    .eff_d      (eff_d),
    .step       (step),
    .height_min (height_min_r),
    .in_push    (in_push),
    .in_height  (in_height),
    .in_full    (in_full),
    .mid_push   (mid_push),
    .mid_item   (front_item),
    .mid_full   (mid_full)
  );

  // short queue lets the front keep taking samples while the back stalls
  hcq_fifo #(
    .item_t (mid_t),
    .DEPTH  (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (front_item),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (back_item),
    .empty     (mid_empty)
  );

  // back: multiplies, code rounding, result sequencing
  hcq_back #(
    .MAX_DIM   (MAX_DIM),
    .MAX_CHUNK (MAX_CHUNK),
    .mid_t     (mid_t)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .eff_w        (eff_w),
    .step         (step),
    .height_scale (height_scale_r),
    .world_scale  (world_scale_r),
    .mid_item     (back_item),
    .mid_empty    (mid_empty),
    .mid_pop      (mid_pop),
    .res_item     (res_item),
    .res_push     (res_push),
    .res_full     (res_full)
  );

  // result queue decouples the consumer from the back end
  hcq_fifo #(
    .item_t (hcq_pkg::res_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_item),
    .empty     (out_empty)
  );

  assign out_result_kind         = out_item.result_kind;
  assign out_quantized_height    = out_item.quantized_height;
  assign out_chunk_index         = out_item.chunk_index;
  assign out_local_index         = out_item.local_index;
  assign out_next_source_address = out_item.next_source_address;
  assign out_box_min_x           = out_item.box_min_x;
  assign out_box_min_y           = out_item.box_min_y;
  assign out_box_min_z           = out_item.box_min_z;
  assign out_box_max_x           = out_item.box_max_x;
  assign out_box_max_y           = out_item.box_max_y;
  assign out_box_max_z           = out_item.box_max_z;
  assign out_last_of_run         = out_item.last_of_run;

endmodule

>>> rtl/hcq_checker.sv
module hcq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [1:0]         out_result_kind,
  input logic [15:0]        out_quantized_height,
  input logic [23:0]        out_chunk_index,
  input logic [15:0]        out_local_index,
  input logic [23:0]        out_next_source_address,
  input logic [36:0]        out_box_min_x,
  input logic [36:0]        out_box_max_x,
  input logic signed [31:0] out_box_min_y,
  input logic signed [31:0] out_box_max_y,
  input logic               out_last_of_run
);

  logic show;
  logic box;

  assign show = !out_empty;
  assign box  = show && (out_result_kind != hcq_pkg::KIND_SAMPLE);

  // hold a waiting result until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (show && !out_pop) |=> (show && $stable(out_result_kind) && $stable(out_chunk_index)
      && $stable(out_next_source_address) && $stable(out_quantized_height)))
    else $error("waiting result changed before pop");

  a_box_shape: assert property (@(posedge clk) disable iff (!rst_n)
    box |-> (out_last_of_run && (out_quantized_height == '0) && (out_local_index == '0)))
    else $error("box beat carries sample fields");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    box |-> ((out_box_min_y <= out_box_max_y) && (out_box_min_x <= out_box_max_x)))
    else $error("box bounds out of order");

  a_box_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (show && out_pop && (out_result_kind == hcq_pkg::KIND_SAMPLE) && !out_last_of_run)
      |=> (out_empty || ((out_result_kind != hcq_pkg::KIND_SAMPLE)
        && $stable(out_chunk_index) && $stable(out_next_source_address))))
    else $error("chunk-end sample not followed by its box");

  a_sample_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (box && out_pop) |=> (out_empty || (out_result_kind == hcq_pkg::KIND_SAMPLE)))
    else $error("box not followed by a sample beat");

endmodule

bind heightfield_chunk_quantizer_top hcq_checker u_hcq_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_empty               (out_empty),
  .out_pop                 (out_pop),
  .out_result_kind         (out_result_kind),
  .out_quantized_height    (out_quantized_height),
  .out_chunk_index         (out_chunk_index),
  .out_local_index         (out_local_index),
  .out_next_source_address (out_next_source_address),
  .out_box_min_x           (out_box_min_x),
  .out_box_max_x           (out_box_max_x),
  .out_box_min_y           (out_box_min_y),
  .out_box_max_y           (out_box_max_y),
  .out_last_of_run         (out_last_of_run)
);
